/* sv/bcdm_pkg.sv */
// Package with the shared sizes, state encoding and control structs of the BCD multiplier.
package bcdm_pkg;

   localparam int OPERAND_DIGITS_DEF  = 15;
   localparam int MULTIPLIER_BITS_DEF = 32;

   localparam int OPERAND_W   = 60;
   localparam int MULTIPLIER_W = 32;
   localparam int PRODUCT_DIGITS = 32;
   localparam int PRODUCT_W   = 4 * PRODUCT_DIGITS;
   localparam int CHUNK_W     = PRODUCT_W / 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUT_LO,
      ST_OUT_HI
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic chunk_hi;
   } cmd_type;

   typedef struct packed {
      logic invalid;
      logic last_bit;
   } status_type;

endpackage

/* sv/bcdm_datapath.sv */
// Datapath of the BCD multiplier: accumulator, multiple, multiplier shift register and counter.
module bcdm_datapath #(
   parameter int OPERAND_DIGITS  = bcdm_pkg::OPERAND_DIGITS_DEF,
   parameter int MULTIPLIER_BITS = bcdm_pkg::MULTIPLIER_BITS_DEF
) (
   input  logic                            clock,
   input  logic [bcdm_pkg::OPERAND_W-1:0]  operand_digits,
   input  logic                            operand_negative,
   input  logic [bcdm_pkg::MULTIPLIER_W-1:0] multiplier,
   input  bcdm_pkg::cmd_type               cmd,
   output bcdm_pkg::status_type            status,
   output logic [bcdm_pkg::CHUNK_W-1:0]    product_chunk,
   output logic                            product_negative,
   output logic                            invalid_digit
);

   localparam int PW    = bcdm_pkg::PRODUCT_W;
   localparam int ND    = bcdm_pkg::PRODUCT_DIGITS;
   localparam int CNT_W = (MULTIPLIER_BITS > 1) ? $clog2(MULTIPLIER_BITS) : 1;

   // Decimal add with an excess-6 bias: one binary add, then per-digit correction.
   function automatic logic [PW-1:0] bcd_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW-1:0] bias;
      logic [PW:0]   sum;
      logic [PW:0]   carries;
      logic [PW-1:0] r;
      for (int i = 0; i < ND; i++) begin
         bias[4*i +: 4] = a[4*i +: 4] + 4'd6;
      end
      sum     = {1'b0, bias} + {1'b0, b};
      carries = {1'b0, bias} ^ {1'b0, b} ^ sum;
      for (int i = 0; i < ND; i++) begin
         if (carries[4*i+4]) begin
            r[4*i +: 4] = sum[4*i +: 4];
         end else begin
            r[4*i +: 4] = sum[4*i +: 4] - 4'd6;
         end
      end
      return r;
   endfunction

   // Decimal double: digits of five or more get three added, then the word shifts left.
   function automatic logic [PW-1:0] bcd_double(input logic [PW-1:0] v);
      logic [PW-1:0] cor;
      for (int i = 0; i < ND; i++) begin
         if (v[4*i +: 4] >= 4'd5) begin
            cor[4*i +: 4] = v[4*i +: 4] + 4'd3;
         end else begin
            cor[4*i +: 4] = v[4*i +: 4];
         end
      end
      return {cor[PW-2:0], 1'b0};
   endfunction

   logic [PW-1:0]              acc_ff, acc_in;
   logic [PW-1:0]              mult_ff, mult_in;
   logic [MULTIPLIER_BITS-1:0] mul_ff, mul_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       neg_ff, neg_in;
   logic                       invalid_ff, invalid_in;
   logic [PW-1:0]              load_mult;
   logic                       load_invalid;

   always_comb begin
      load_mult    = '0;
      load_invalid = 1'b0;
      for (int i = 0; i < OPERAND_DIGITS; i++) begin
         load_mult[4*i +: 4] = operand_digits[4*i +: 4];
         if (operand_digits[4*i +: 4] > 4'd9) begin
            load_invalid = 1'b1;
         end
      end
   end

   always_comb begin
      acc_in     = acc_ff;
      mult_in    = mult_ff;
      mul_in     = mul_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      invalid_in = invalid_ff;
      if (cmd.load) begin
         acc_in     = '0;
         mult_in    = load_mult;
         mul_in     = multiplier[MULTIPLIER_BITS-1:0];
         cnt_in     = CNT_W'(MULTIPLIER_BITS - 1);
         neg_in     = operand_negative;
         invalid_in = load_invalid;
      end else if (cmd.step) begin
         if (mul_ff[0]) begin
            acc_in = bcd_add(acc_ff, mult_ff);
         end
         mult_in = bcd_double(mult_ff);
         mul_in  = mul_ff >> 1;
         cnt_in  = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      mult_ff    <= mult_in;
      mul_ff     <= mul_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      invalid_ff <= invalid_in;
   end

   assign status.invalid  = invalid_ff;
   assign status.last_bit = (cnt_ff == '0);

   assign product_chunk    = cmd.chunk_hi ? acc_ff[PW-1:bcdm_pkg::CHUNK_W]
                                          : acc_ff[bcdm_pkg::CHUNK_W-1:0];
   assign product_negative = neg_ff & (|acc_ff) & ~invalid_ff;
   assign invalid_digit    = invalid_ff;

endmodule

/* sv/bcdm_ctrl.sv */
// Controller state machine of the BCD multiplier.
module bcdm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  bcdm_pkg::status_type status,
   output bcdm_pkg::cmd_type    cmd
);

   bcdm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcdm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = bcdm_pkg::ST_RUN;
            end
         end
         bcdm_pkg::ST_RUN: begin
            if (status.invalid || status.last_bit) begin
               state_in = bcdm_pkg::ST_OUT_LO;
            end
         end
         bcdm_pkg::ST_OUT_LO: begin
            if (rsp_tready) begin
               state_in = bcdm_pkg::ST_OUT_HI;
            end
         end
         bcdm_pkg::ST_OUT_HI: begin
            if (rsp_tready) begin
               state_in = bcdm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcdm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      cmd.load     = 1'b0;
      cmd.step     = 1'b0;
      cmd.chunk_hi = 1'b0;
      case (state_ff)
         bcdm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         bcdm_pkg::ST_RUN: begin
            cmd.step = ~status.invalid;
         end
         bcdm_pkg::ST_OUT_LO: begin
            rsp_tvalid = 1'b1;
         end
         bcdm_pkg::ST_OUT_HI: begin
            rsp_tvalid   = 1'b1;
            cmd.chunk_hi = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcdm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/bcd_multiply_by_integer_top.sv */
// Top level of the packed BCD by binary integer shift-and-add multiplier.
// A word is accepted only while the block is idle. The run state then does a single
// decimal add-and-double step per multiplier bit (none for an invalid operand), after
// which the low result word and then the high one are shown, each held until taken.
// Reset is synchronous and active high and returns the controller to idle.
module bcd_multiply_by_integer_top #(
   parameter int OPERAND_DIGITS  = bcdm_pkg::OPERAND_DIGITS_DEF,
   parameter int MULTIPLIER_BITS = bcdm_pkg::MULTIPLIER_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operand_digits[59:0], operand_negative[60], multiplier[92:61], zero fill
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // product_chunk[63:0], product_negative[64], invalid_digit[65], zero fill
   output logic [71:0] rsp_tdata,
   // chunk_index[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   bcdm_pkg::cmd_type    cmd;
   bcdm_pkg::status_type status;
   logic [bcdm_pkg::CHUNK_W-1:0] product_chunk;
   logic product_negative;
   logic invalid_digit;

   bcdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bcdm_datapath #(
      .OPERAND_DIGITS  (OPERAND_DIGITS),
      .MULTIPLIER_BITS (MULTIPLIER_BITS)
   ) u_datapath (
      .clock            (clock),
      .operand_digits   (req_tdata[59:0]),
      .operand_negative (req_tdata[60]),
      .multiplier       (req_tdata[92:61]),
      .cmd              (cmd),
      .status           (status),
      .product_chunk    (product_chunk),
      .product_negative (product_negative),
      .invalid_digit    (invalid_digit)
   );

   assign rsp_tdata = {6'd0, invalid_digit, product_negative, product_chunk};
   assign rsp_tuser = cmd.chunk_hi;
   assign rsp_tlast = cmd.chunk_hi;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("input accepted while a result word is pending");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65]) |-> (rsp_tdata[63:0] == 64'd0 && !rsp_tdata[64]))
      else $error("invalid operand gave a nonzero or negative product");

   a_accept_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result word shown right after acceptance");

   a_hi_follows_lo: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tlast))
      else $error("high chunk did not follow the low chunk");

endmodule

/* test/bcd_multiply_by_integer_checker.sv */
// Checker that predicts each BCD product from the accepted request words and compares the result words.
`timescale 1ns / 100ps

module bcd_multiply_by_integer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [63:0] chunk;
      logic        chunk_hi;
      logic        negative;
      logic        invalid;
      logic        last;
   } chunk_word_type;

   chunk_word_type product_chunks[$];
   int             misses = 0;

   function automatic logic has_bad_digit(input logic [59:0] digits);
      int i;
      for (i = 0; i < 15; i++)
         if (digits[4*i +: 4] > 4'd9)
            return 1'b1;
      return 1'b0;
   endfunction

   // The operand is taken to binary, multiplied, and turned back into 32 decimal digits.
   function automatic logic [127:0] decimal_product(input logic [59:0] digits,
                                                    input logic [31:0] mult);
      logic [127:0] value;
      logic [127:0] bcd;
      int           i;
      value = '0;
      for (i = 14; i >= 0; i--)
         value = value * 128'd10 + {124'd0, digits[4*i +: 4]};
      value = value * {96'd0, mult};
      bcd = '0;
      for (i = 0; i < 32; i++) begin
         bcd[4*i +: 4] = 4'(value % 128'd10);
         value = value / 128'd10;
      end
      return bcd;
   endfunction

   task automatic note_miss(input string what, input chunk_word_type want,
                            input chunk_word_type seen);
      if (misses < 10) begin
         $display("%0t: %s: expected chunk=%h hi=%b neg=%b inv=%b last=%b", $time, what,
                  want.chunk, want.chunk_hi, want.negative, want.invalid, want.last);
         $display("      got      chunk=%h hi=%b neg=%b inv=%b last=%b",
                  seen.chunk, seen.chunk_hi, seen.negative, seen.invalid, seen.last);
      end
      misses++;
   endtask

   always @(posedge clock) begin : watch
      chunk_word_type want;
      chunk_word_type seen;
      logic           bad;
      logic           sign;
      logic [127:0]   product;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            bad = has_bad_digit(req_tdata[59:0]);
            product = bad ? '0 : decimal_product(req_tdata[59:0], req_tdata[92:61]);
            sign = req_tdata[60] && !bad && (product != '0);
            product_chunks.push_back('{product[63:0], 1'b0, sign, bad, 1'b0});
            product_chunks.push_back('{product[127:64], 1'b1, sign, bad, 1'b1});
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = '{rsp_tdata[63:0], rsp_tuser, rsp_tdata[64], rsp_tdata[65], rsp_tlast};
            if (product_chunks.size() == 0) begin
               note_miss("word with nothing expected", '0, seen);
            end else begin
               want = product_chunks.pop_front();
               if (want !== seen)
                  note_miss("product mismatch", want, seen);
            end
         end
      end
      fail_count <= misses;
      pending <= product_chunks.size();
   end

endmodule

/* test/bcd_multiply_by_integer_top_tb.sv */
// Testbench top that drives the BCD multiplier with directed and random words and gives the verdict.
`timescale 1ns / 100ps

module bcd_multiply_by_integer_top_tb;

   localparam int RANDOM_ITEMS = 750;
   localparam int CALM_FROM    = 650;
   localparam int QUIET_LIMIT  = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          pending;
   logic        bursty;
   logic        calm;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bcd_multiply_by_integer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   bcd_multiply_by_integer_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   task automatic send_word(input logic [59:0] digits, input logic neg, input logic [31:0] mult);
      if (bursty && !calm && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         if ($urandom_range(0, 1) == 1)
            while (pending != 0) @(posedge clock);
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, mult, neg, digits};
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (bursty && !calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int           n;
      int           used;
      int           i;
      logic [59:0]  digits;
      logic [31:0]  mult;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      bursty = 1'b1;
      calm = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_word(60'h000000000000000, 1'b0, 32'h00000000);
      send_word(60'h999999999999999, 1'b0, 32'hFFFFFFFF);
      send_word(60'h999999999999999, 1'b1, 32'hFFFFFFFF);
      send_word(60'h000000000000000, 1'b1, 32'hFFFFFFFF);
      send_word(60'h123456789012345, 1'b1, 32'h00000000);
      send_word(60'h000000000000001, 1'b0, 32'h00000001);
      send_word(60'h000000000000005, 1'b0, 32'h00000002);
      send_word(60'h000000000000009, 1'b1, 32'h80000000);
      send_word(60'h999999999999999, 1'b0, 32'h00000001);
      send_word(60'h12345678901234A, 1'b0, 32'h00000007);
      send_word(60'hF00000000000001, 1'b1, 32'h00000003);
      send_word(60'hFFFFFFFFFFFFFFF, 1'b1, 32'hFFFFFFFF);
      send_word(60'h0000000B0000000, 1'b0, 32'h00000000);
      send_word(60'h500000000000000, 1'b0, 32'h55555555);
      send_word(60'h123456789012345, 1'b1, 32'hAAAAAAAA);
      send_word(60'h999999999999999, 1'b0, 32'h0000000A);
      send_word(60'h000000000000001, 1'b1, 32'hFFFFFFFF);
      send_word(60'h987654321098765, 1'b0, 32'h3B9ACA00);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0)
            bursty = ($urandom_range(0, 2) != 0);
         if (n == CALM_FROM)
            calm = 1'b1;
         // Most operands are well formed; one in four has a random number of significant digits, the rest all 15.
         used = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 15;
         digits = '0;
         for (i = 0; i < used; i++)
            digits[4*i +: 4] = 4'($urandom_range(0, 9));
         case ($urandom_range(0, 11))
            0:       digits[4*$urandom_range(0, 14) +: 4] = 4'($urandom_range(10, 15));
            1:       digits = 60'({$urandom, $urandom});
            default: ;
         endcase
         case ($urandom_range(0, 5))
            1:       mult = $urandom_range(0, 255);
            2:       mult = 32'h1 << $urandom_range(0, 31);
            3:       mult = ~(32'h1 << $urandom_range(0, 31));
            default: mult = $urandom;
         endcase
         send_word(digits, 1'($urandom_range(0, 1)), mult);
      end
      req_tvalid <= 1'b0;

      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
